// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by pidpi_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- rtl/pidpi_pkg.sv -----
// shared constants and types of the pid controller
`timescale 1ns / 1ps

package pidpi_pkg;

    localparam int SAMPLE_W_DEF = 16;
    localparam int COEF_W       = 16;
    localparam int ERR_W        = 24;
    localparam int SUM_W        = 40;
    localparam int RES_W        = 32;
    localparam int ACC_W        = 64;
    localparam int SPLIT        = 24;
    localparam int OPB_MIN      = 28;
    localparam int REG_IDX_W    = 3;
    localparam int MODE_W       = 2;

    localparam logic [REG_IDX_W-1:0] REG_KP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KD   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GIN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GOUT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd5;

    localparam logic [MODE_W-1:0] MODE_POS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INC = 2'd1;

    localparam logic signed [COEF_W-1:0] GAIN_ONE = 16'sd256;

    typedef struct packed {
        logic fire;   // start a multiply this cycle
        logic accum;  // add the product into the accumulator
        logic hi;     // product is an upper partial, weight 2^SPLIT
        logic clr;    // clear the accumulator
    } mac_ctrl_t;

endpackage

// ----- rtl/pid_positional_incremental.sv -----
// pid controller top level: configuration registers, sequencer and shared multiplier
// a request is taken only in idle; the next one waits until the result is in the output register
// the single shared 16 x 28 multiplier runs the error scaling and each coefficient product, and in
//   incremental mode also the two output-gain partials
// a finished result waits in the output register while the next request is taken
// reset (aresetn low, synchronous) clears error history, integral and held result, and loads register defaults
`timescale 1ns / 1ps

module pid_positional_incremental
    import pidpi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // target, actual (each SAMPLE_WIDTH bits, signed), zero padded to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // drive (32 bits, signed)
    output logic [RES_W-1:0]                        m_tdata,
    input  logic                                    cfg_wr_en,
    input  logic [REG_IDX_W-1:0]                    cfg_addr,
    input  logic [COEF_W-1:0]                       cfg_wdata
);

    localparam int OPB_W = (SAMPLE_WIDTH + 1 > OPB_MIN) ? SAMPLE_WIDTH + 1 : OPB_MIN;

    logic signed [COEF_W-1:0]        kp_reg;
    logic signed [COEF_W-1:0]        ki_reg;
    logic signed [COEF_W-1:0]        kd_reg;
    logic signed [COEF_W-1:0]        gin_reg;
    logic signed [COEF_W-1:0]        gout_reg;
    logic [MODE_W-1:0]               mode_reg;

    mac_ctrl_t                       ctrl;
    logic signed [COEF_W-1:0]        op_a;
    logic signed [OPB_W-1:0]         op_b;
    logic signed [COEF_W+OPB_W-1:0]  prod;
    logic signed [ACC_W-1:0]         acc;
    logic signed [RES_W-1:0]         drive;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            gin_reg  <= GAIN_ONE;
            gout_reg <= GAIN_ONE;
            mode_reg <= MODE_POS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KP:   kp_reg   <= cfg_wdata;
                REG_KI:   ki_reg   <= cfg_wdata;
                REG_KD:   kd_reg   <= cfg_wdata;
                REG_GIN:  gin_reg  <= cfg_wdata;
                REG_GOUT: gout_reg <= cfg_wdata;
                REG_MODE: mode_reg <= cfg_wdata[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pidpi_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .OPB_W        (OPB_W)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .target      ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .actual      ($signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (drive),
        .prop_coeff  (kp_reg),
        .integ_coeff (ki_reg),
        .deriv_coeff (kd_reg),
        .in_gain     (gin_reg),
        .out_gain    (gout_reg),
        .loop_mode   (mode_reg),
        .ctrl        (ctrl),
        .op_a        (op_a),
        .op_b        (op_b),
        .prod        (prod),
        .acc         (acc)
    );

    pidpi_mac #(
        .OPB_W (OPB_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .prod    (prod),
        .acc     (acc)
    );

    assign m_tdata = drive;

endmodule

// ----- rtl/pidpi_mac.sv -----
// shared multiplier with registered product and accumulator
`timescale 1ns / 1ps

module pidpi_mac
    import pidpi_pkg::*;
#(
    parameter int OPB_W = OPB_MIN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mac_ctrl_t                        ctrl,
    input  logic signed [COEF_W-1:0]         op_a,
    input  logic signed [OPB_W-1:0]          op_b,
    output logic signed [COEF_W+OPB_W-1:0]   prod,
    output logic signed [ACC_W-1:0]          acc
);

    localparam int PROD_W = COEF_W + OPB_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pend_reg;
    logic                     hi_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);
    assign acc_next = acc_reg + (hi_reg ? (prod_ext <<< SPLIT) : prod_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end else begin
            pend_reg <= ctrl.fire & ctrl.accum;
            if (ctrl.clr) begin
                acc_reg <= '0;
            end else if (pend_reg) begin
                acc_reg <= acc_next;
            end
        end
        if (ctrl.fire) begin
            prod_reg <= op_a * op_b;
            hi_reg   <= ctrl.hi;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ----- rtl/pidpi_core.sv -----
// sequencer, controller state and output register of the pid controller
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidpi_core
    import pidpi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
    parameter int OPB_W        = OPB_MIN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic signed [SAMPLE_WIDTH-1:0]   target,
    input  logic signed [SAMPLE_WIDTH-1:0]   actual,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic signed [RES_W-1:0]          m_tdata,
    input  logic signed [COEF_W-1:0]         prop_coeff,
    input  logic signed [COEF_W-1:0]         integ_coeff,
    input  logic signed [COEF_W-1:0]         deriv_coeff,
    input  logic signed [COEF_W-1:0]         in_gain,
    input  logic signed [COEF_W-1:0]         out_gain,
    input  logic [MODE_W-1:0]                loop_mode,
    output mac_ctrl_t                        ctrl,
    output logic signed [COEF_W-1:0]         op_a,
    output logic signed [OPB_W-1:0]          op_b,
    input  logic signed [COEF_W+OPB_W-1:0]   prod,
    input  logic signed [ACC_W-1:0]          acc
);

    localparam int PROD_W = COEF_W + OPB_W;
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int D1_W   = ERR_W + 1;
    localparam int D2_W   = ERR_W + 3;
    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_MUL,
        ST_ERR_SAT,
        ST_MAC,
        ST_DRAIN,
        ST_GAIN_LO,
        ST_GAIN_HI,
        ST_GDRAIN,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [1:0]                term_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [ERR_W-1:0]   e1_reg;
    logic signed [ERR_W-1:0]   e2_reg;
    logic signed [D1_W-1:0]    d1_reg;
    logic signed [D2_W-1:0]    d2_reg;
    logic signed [SUM_W-1:0]   integ_reg;
    logic signed [RES_W-1:0]   held_reg;
    logic signed [OPB_W-1:0]   inc_hi_reg;
    logic                      m_valid_reg;
    logic signed [RES_W-1:0]   m_data_reg;

    logic                      is_pos;
    logic                      is_inc;
    logic                      out_free;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [D1_W-1:0]    d1_next;
    logic signed [D2_W-1:0]    d2_next;
    logic signed [SUM_W:0]     isum;
    logic signed [SUM_W-1:0]   integ_next;
    logic signed [ACC_W-1:0]   pos_sh;
    logic signed [ACC_W:0]     inc_sum;
    logic signed [RES_W-1:0]   pos_res;
    logic signed [RES_W-1:0]   inc_res;
    logic signed [RES_W-1:0]   res_next;

    assign is_pos   = (loop_mode == MODE_POS);
    assign is_inc   = (loop_mode == MODE_INC);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // error saturation: in range when the bits above the sign all agree with it
    always_comb begin
        if ((&prod[PROD_W-1:ERR_W-1]) || !(|prod[PROD_W-1:ERR_W-1])) begin
            err_next = prod[ERR_W-1:0];
        end else if (prod[PROD_W-1]) begin
            err_next = ERR_MIN;
        end else begin
            err_next = ERR_MAX;
        end
    end

    assign d1_next = D1_W'(err_next) - D1_W'(e1_reg);
    assign d2_next = D2_W'(err_next) - (D2_W'(e1_reg) <<< 1) + D2_W'(e2_reg);
    assign isum    = (SUM_W+1)'(integ_reg) + (SUM_W+1)'(err_next);

    always_comb begin
        if (isum[SUM_W] == isum[SUM_W-1]) begin
            integ_next = isum[SUM_W-1:0];
        end else if (isum[SUM_W]) begin
            integ_next = SUM_MIN;
        end else begin
            integ_next = SUM_MAX;
        end
    end

    // result: positional drops 8 fraction bits, incremental drops 16 and adds to held
    assign pos_sh  = acc >>> 8;
    assign inc_sum = (ACC_W+1)'(held_reg) + (ACC_W+1)'(acc >>> 16);

    always_comb begin
        if ((&pos_sh[ACC_W-1:RES_W-1]) || !(|pos_sh[ACC_W-1:RES_W-1])) begin
            pos_res = pos_sh[RES_W-1:0];
        end else if (pos_sh[ACC_W-1]) begin
            pos_res = RES_MIN;
        end else begin
            pos_res = RES_MAX;
        end
        if ((&inc_sum[ACC_W:RES_W-1]) || !(|inc_sum[ACC_W:RES_W-1])) begin
            inc_res = inc_sum[RES_W-1:0];
        end else if (inc_sum[ACC_W]) begin
            inc_res = RES_MIN;
        end else begin
            inc_res = RES_MAX;
        end
        if (is_pos) begin
            res_next = pos_res;
        end else if (is_inc) begin
            res_next = inc_res;
        end else begin
            res_next = '0;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        ctrl = '0;
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_ERR_MUL: begin
                ctrl.fire = 1'b1;
                ctrl.clr  = 1'b1;
                op_a      = in_gain;
                op_b      = OPB_W'(diff_reg);
            end
            ST_MAC: begin
                ctrl.fire  = 1'b1;
                ctrl.accum = 1'b1;
                if (is_pos) begin
                    case (term_reg)
                        2'd0: begin
                            op_a = prop_coeff;
                            op_b = OPB_W'(e_reg);
                        end
                        2'd1: begin
                            op_a = deriv_coeff;
                            op_b = OPB_W'(d1_reg);
                        end
                        2'd2: begin
                            // lower integral bits taken as unsigned
                            op_a = integ_coeff;
                            op_b = OPB_W'({1'b0, integ_reg[SPLIT-1:0]});
                        end
                        default: begin
                            op_a    = integ_coeff;
                            op_b    = OPB_W'($signed(integ_reg[SUM_W-1:SPLIT]));
                            ctrl.hi = 1'b1;
                        end
                    endcase
                end else begin
                    case (term_reg)
                        2'd0: begin
                            op_a = prop_coeff;
                            op_b = OPB_W'(d1_reg);
                        end
                        2'd1: begin
                            op_a = integ_coeff;
                            op_b = OPB_W'(e_reg);
                        end
                        default: begin
                            op_a = deriv_coeff;
                            op_b = OPB_W'(d2_reg);
                        end
                    endcase
                end
            end
            ST_GAIN_LO: begin
                // increment is read before the accumulator clears
                ctrl.fire  = 1'b1;
                ctrl.accum = 1'b1;
                ctrl.clr   = 1'b1;
                op_a       = out_gain;
                op_b       = OPB_W'({1'b0, acc[SPLIT-1:0]});
            end
            ST_GAIN_HI: begin
                ctrl.fire  = 1'b1;
                ctrl.accum = 1'b1;
                ctrl.hi    = 1'b1;
                op_a       = out_gain;
                op_b       = inc_hi_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            term_reg    <= '0;
            e_reg       <= '0;
            e1_reg      <= '0;
            e2_reg      <= '0;
            integ_reg   <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        diff_reg  <= DIFF_W'(target) - DIFF_W'(actual);
                        state_reg <= ST_ERR_MUL;
                    end
                end
                ST_ERR_MUL: begin
                    state_reg <= ST_ERR_SAT;
                end
                ST_ERR_SAT: begin
                    e_reg    <= err_next;
                    e1_reg   <= err_next;
                    e2_reg   <= e1_reg;
                    d1_reg   <= d1_next;
                    d2_reg   <= d2_next;
                    term_reg <= '0;
                    if (is_pos) begin
                        integ_reg <= integ_next;
                    end
                    state_reg <= (is_pos || is_inc) ? ST_MAC : ST_DONE;
                end
                ST_MAC: begin
                    term_reg <= term_reg + 2'd1;
                    if ((is_pos && term_reg == 2'd3) || (!is_pos && term_reg == 2'd2)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= is_pos ? ST_DONE : ST_GAIN_LO;
                end
                ST_GAIN_LO: begin
                    inc_hi_reg <= $signed(acc[SPLIT+OPB_W-1:SPLIT]);
                    state_reg  <= ST_GAIN_HI;
                end
                ST_GAIN_HI: begin
                    state_reg <= ST_GDRAIN;
                end
                ST_GDRAIN: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        held_reg   <= res_next;
                        m_data_reg <= res_next;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_accept_starts, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == ST_ERR_MUL), "accepted request did not start error multiply")
    `ASSERT_CLK(a_disabled_zero, aclk, aresetn, (state_reg == ST_DONE && out_free && !is_pos && !is_inc) |=> (m_tvalid && m_tdata == '0), "disabled mode gave nonzero drive")
    `ASSERT_CLK(a_hist_shift, aclk, aresetn, (state_reg == ST_ERR_SAT) |=> (e2_reg == $past(e1_reg) && e1_reg == e_reg), "error history did not shift")

endmodule
